FILE: rtl/dq_pkg.sv
// Shared types and constants of the double-ended queue.
`default_nettype none
package dq_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = 5;
	localparam int MODE_W = 3;
	localparam int STAT_W = 2;

	// Operation codes carried in the mode field.
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_DONE       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL       = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY      = 2'd2;

	localparam logic [DATA_W-1:0] DATA_ALL_ONES   = '1;
	localparam logic [CNT_W-1:0]  CAPACITY_RESET  = 5'd16;

	// Occupancy and outcome of the last operation, from the pointer unit.
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  count;
		logic              full;
		logic              empty;
	} dq_info_t;

endpackage
`default_nettype wire

FILE: rtl/dq_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
`default_nettype none
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr_a,
	output logic      [WIDTH-1:0] rd_data_a,
	input  wire logic [AW-1:0]    rd_addr_b,
	output logic      [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule
`default_nettype wire

FILE: rtl/dq_ptr.sv
// Head pointer and element count of the ring, with per-operation decode.
`default_nettype none
module dq_ptr #(
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     op_en,
	input  wire logic [dq_pkg::MODE_W-1:0] mode,
	input  wire logic [dq_pkg::CNT_W-1:0]  capacity,
	output logic                          wr_en,
	output logic      [AW-1:0]            wr_addr,
	output logic      [AW-1:0]            front_addr,
	output logic      [AW-1:0]            back_addr,
	output dq_pkg::dq_info_t              info
);
	import dq_pkg::*;

	localparam int SW = ((AW > CNT_W) ? AW : CNT_W) + 1;
	localparam int DepthCap = (DEPTH > 31) ? 31 : DEPTH;
	localparam logic [CNT_W-1:0] DepthCapL = CNT_W'(DepthCap);
	localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

	logic [AW-1:0]     head_q, head_d, head_inc, head_dec;
	logic [CNT_W-1:0]  count_q, count_d, eff_cap, back_off;
	logic [STAT_W-1:0] status_q, status_d;
	logic              full_now, empty_now, wr_ok;

	// Offsets never exceed DEPTH, so one conditional subtract wraps the sum.
	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
		input logic [CNT_W-1:0] off);
		logic [SW-1:0] s;
		s = SW'(base) + SW'(off);
		if (s >= SW'(DEPTH)) begin
			s = s - SW'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign eff_cap   = (capacity > DepthCapL) ? DepthCapL : capacity;
	assign full_now  = (count_q >= eff_cap);
	assign empty_now = (count_q == '0);
	assign head_inc  = (head_q == LastIdx) ? '0 : head_q + 1'b1;
	assign head_dec  = (head_q == '0) ? LastIdx : head_q - 1'b1;
	assign back_off  = empty_now ? '0 : count_q - 1'b1;

	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		status_d = STAT_DONE;
		wr_ok    = 1'b0;
		wr_addr  = ring_add(head_q, count_q);
		unique case (mode)
			MODE_PUSH_BACK: begin
				if (full_now) begin
					status_d = STAT_FULL;
				end else begin
					wr_ok   = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			MODE_PUSH_FRONT: begin
				wr_addr = head_dec;
				if (full_now) begin
					status_d = STAT_FULL;
				end else begin
					wr_ok   = 1'b1;
					head_d  = head_dec;
					count_d = count_q + 1'b1;
				end
			end
			MODE_POP_BACK: begin
				if (empty_now) begin
					status_d = STAT_EMPTY;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			MODE_POP_FRONT: begin
				if (empty_now) begin
					status_d = STAT_EMPTY;
				end else begin
					head_d  = head_inc;
					count_d = count_q - 1'b1;
				end
			end
			MODE_CLEAR: begin
				head_d  = '0;
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign wr_en = op_en && wr_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			status_q <= STAT_DONE;
		end else if (op_en) begin
			head_q   <= head_d;
			count_q  <= count_d;
			status_q <= status_d;
		end
	end

	assign front_addr   = head_q;
	assign back_addr    = ring_add(head_q, back_off);
	assign info.status  = status_q;
	assign info.count   = count_q;
	assign info.full    = full_now;
	assign info.empty   = empty_now;

endmodule
`default_nettype wire

FILE: rtl/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words held in a ring RAM.
//
// Input channel: in_valid, in_stall, mode, value. A transfer happens at a rising
// edge where in_valid is high and in_stall is low. Output channel: out_valid,
// out_stall and the result fields; one result follows every input transfer.
// The capacity register is written through cfg_wr_en and cfg_wr_data; the
// user must write it only while the queue is idle, which the block does not
// enforce. Values above DEPTH behave as DEPTH, zero refuses pushes.
//
// An operation passes ST_IDLE, ST_READ and ST_RESP: the transfer edge decodes
// it, writes a pushed word into the RAM and moves the head pointer and count;
// ST_READ reads the front and back words at the new positions; the RAM's
// registered read data are loaded into the output register at the end of
// ST_RESP, once that register is free; no new item is taken before ST_IDLE.
//
// The output register frees the input side: a new item is taken while an
// earlier result still waits. If the receiver stalls, the next result waits in
// the response stage and in_stall stays high until the output register empties.
// Reset empties the queue, sets capacity to 16 and drops out_valid; entries
// are not cleared, since a word is only read after it has been written.
`default_nettype none
module double_ended_queue #(
	parameter int DEPTH = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [dq_pkg::MODE_W-1:0]  mode,
	input  wire logic signed [dq_pkg::DATA_W-1:0] value,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic      [dq_pkg::STAT_W-1:0]  status,
	output logic signed [dq_pkg::DATA_W-1:0] front_value,
	output logic signed [dq_pkg::DATA_W-1:0] back_value,
	output logic      [dq_pkg::CNT_W-1:0]   count,
	output logic                           full_res,
	output logic                           empty_res,
	input  wire logic                      cfg_wr_en,
	input  wire logic [dq_pkg::CNT_W-1:0]   cfg_wr_data
);
	import dq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int DepthCap = (DEPTH > 31) ? 31 : DEPTH;

	// Sequencer states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_RESP = 2'd2;

	logic [1:0]        state_q, state_d;
	logic [CNT_W-1:0]  capacity_q;
	logic              accept, load_out, out_valid_q;
	logic              wr_en;
	logic [AW-1:0]     wr_addr, front_addr, back_addr;
	logic [DATA_W-1:0] front_rd, back_rd;
	dq_info_t          info;

	logic [STAT_W-1:0]        status_q;
	logic signed [DATA_W-1:0] front_q, back_q;
	logic [CNT_W-1:0]         count_q;
	logic                     full_q, empty_q;

	// Configuration: a write lands at once, with no handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	// Only the idle state takes a new item, which keeps the RAM write ahead
	// of the reads that depend on it.
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	// The result moves into the output register when it is empty or draining.
	assign load_out = (state_q == ST_RESP) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	dq_ptr #(
		.DEPTH(DEPTH)
	) u_ptr (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_en      (accept),
		.mode       (mode),
		.capacity   (capacity_q),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.front_addr (front_addr),
		.back_addr  (back_addr),
		.info       (info)
	);

	// The read ports follow the pointers every cycle; no write occurs between
	// the read stage and the response stage, so the read data stay put while
	// the output register is stalled.
	dq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   ($unsigned(value)),
		.rd_addr_a (front_addr),
		.rd_data_a (front_rd),
		.rd_addr_b (back_addr),
		.rd_data_b (back_rd)
	);

	// Output register. An empty queue reports all ones at both ends.
	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= info.status;
			front_q  <= $signed(info.empty ? DATA_ALL_ONES : front_rd);
			back_q   <= $signed(info.empty ? DATA_ALL_ONES : back_rd);
			count_q  <= info.count;
			full_q   <= info.full;
			empty_q  <= info.empty;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign front_value = front_q;
	assign back_value  = back_q;
	assign count       = count_q;
	assign full_res    = full_q;
	assign empty_res   = empty_q;

	// The RAM is written only on the edge where an item is taken.
	a_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> accept)
		else $error("entry write outside an input transfer");

	// A new result appears only after the response stage.
	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_RESP)
		else $error("result raised outside the response stage");

	// The count never passes the usable depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		info.count <= CNT_W'(DepthCap))
		else $error("element count beyond depth");

	// An empty result carries all ones at both ends.
	a_empty_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && empty_res) |->
			($unsigned(front_value) == DATA_ALL_ONES &&
			 $unsigned(back_value) == DATA_ALL_ONES && count == '0))
		else $error("empty result with stale words");

endmodule
`default_nettype wire
